FILE: rtl/mre_pkg.sv
// mre_pkg: shared types, codes and helpers for the matrix rotation engine
// depends on nothing; used by every rtl file of the block
package mre_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = DIM_W + 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ROTATE = 1'b1;

  localparam logic [1:0] ANG_90  = 2'd0;
  localparam logic [1:0] ANG_180 = 2'd1;
  localparam logic [1:0] ANG_270 = 2'd2;
  localparam logic [1:0] ANG_BAD = 2'd3;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [DIM_W-1:0]         row_index;
    logic [DIM_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
    logic [1:0]               angle_code;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     row_last;
    logic                     error_flag;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic wr;
    logic load;
    logic step;
    logic err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_ok;
    logic last;
  } sts_t;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

FILE: rtl/mre_ctrl.sv
// mre_ctrl: sequencer for write and rotate items
// depends on mre_pkg; drives commands into mre_datapath
module mre_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op,
  input  mre_pkg::sts_t     sts,
  output mre_pkg::cmd_t     cmd,
  output logic              busy
);

  mre_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mre_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      mre_pkg::ST_IDLE: begin
        if (start) begin
          if (op == mre_pkg::OP_WRITE) begin
            cmd.wr = 1'b1;
          end else if (sts.req_ok) begin
            cmd.load  = 1'b1;
            state_nxt = mre_pkg::ST_RUN;
          end else begin
            cmd.err = 1'b1;
          end
        end
      end
      mre_pkg::ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = mre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mre_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/mre_datapath.sv
// mre_datapath: element store, dimension registers, walk counters, result register
// depends on mre_pkg; commanded by mre_ctrl
module mre_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mre_pkg::in_item_t             in_item,
  input  mre_pkg::cmd_t                 cmd,
  output mre_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mre_pkg::CNT_W-1:0]     cfg_wdata,
  output logic                          out_strobe,
  output mre_pkg::out_item_t            out_item
);

  logic [mre_pkg::DATA_W-1:0] mem [mre_pkg::DEPTH];

  logic [mre_pkg::CNT_W-1:0]  nr_r, nc_r;
  logic [mre_pkg::DIM_W-1:0]  row_r, col_r, row_nxt, col_nxt;
  logic [mre_pkg::CNT_W-1:0]  cnt_r;
  logic [1:0]                 ang_r;
  logic [mre_pkg::DATA_W-1:0] rd_data_r;
  logic                       rd_vld_r, rd_last_r, err_r;

  logic [mre_pkg::CNT_W-1:0]  rows_out, len;
  logic [mre_pkg::DIM_W-1:0]  nr_m1, nc_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_r <= mre_pkg::CNT_W'(1);
      nc_r <= mre_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == mre_pkg::CFG_ROW_COUNT) begin
        nr_r <= mre_pkg::clamp_dim(cfg_wdata);
      end else begin
        nc_r <= mre_pkg::clamp_dim(cfg_wdata);
      end
    end
  end

  assign nr_m1    = mre_pkg::DIM_W'(nr_r - mre_pkg::CNT_W'(1));
  assign nc_m1    = mre_pkg::DIM_W'(nc_r - mre_pkg::CNT_W'(1));
  assign rows_out = (in_item.angle_code == mre_pkg::ANG_180) ? nr_r : nc_r;
  assign len      = (in_item.angle_code == mre_pkg::ANG_180) ? nc_r : nr_r;

  assign sts.req_ok = (in_item.angle_code != mre_pkg::ANG_BAD) &&
                      ({1'b0, in_item.row_index} < rows_out);
  assign sts.last   = (cnt_r == mre_pkg::CNT_W'(1));

  // starting corner of the walk
  always_comb begin
    row_nxt = '0;
    col_nxt = '0;
    case (in_item.angle_code)
      mre_pkg::ANG_90: begin
        row_nxt = nr_m1;
        col_nxt = in_item.row_index;
      end
      mre_pkg::ANG_180: begin
        row_nxt = nr_m1 - in_item.row_index;
        col_nxt = nc_m1;
      end
      default: begin
        row_nxt = '0;
        col_nxt = nc_m1 - in_item.row_index;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      cnt_r <= len;
      ang_r <= in_item.angle_code;
    end else if (cmd.step) begin
      cnt_r <= cnt_r - mre_pkg::CNT_W'(1);
      case (ang_r)
        mre_pkg::ANG_90:  row_r <= row_r - mre_pkg::DIM_W'(1);
        mre_pkg::ANG_180: col_r <= col_r - mre_pkg::DIM_W'(1);
        default:          row_r <= row_r + mre_pkg::DIM_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[{in_item.row_index, in_item.col_index}] <= in_item.element_value;
    end
    rd_data_r <= mem[{row_r, col_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.step;
      err_r    <= cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r <= sts.last;
  end

  assign out_strobe          = rd_vld_r | err_r;
  assign out_item.out_value  = err_r ? '0 : rd_data_r;
  assign out_item.row_last   = err_r | rd_last_r;
  assign out_item.error_flag = err_r;

endmodule

FILE: rtl/matrix_rotation_engine_core.sv
// matrix_rotation_engine_core: top level of the matrix rotation engine
// depends on mre_pkg, mre_ctrl, mre_datapath
//
// Usage:
//   in_item is taken at a clock edge with start high and busy low.
//   A write item stores element_value at (row_index, col_index) and gives
//   no result; busy stays low.
//   A rotate item with a good angle and row raises busy until every element
//   of the output row (1 to 64) is read; the store is read once per cycle
//   through its single read port, which sets the rate of one element a
//   cycle. Taking the item loads the walk counters; each element passes
//   the registered store read to out_item, row_last set on the final one.
//   A bad angle or row gives one error result the cycle after the item is
//   taken, with busy staying low.
//   Each result is valid for the one cycle out_strobe is high; the receiver
//   cannot stall, so nothing is held back.
//   cfg_we writes row_count (index 0) or col_count (index 1) at once.
//   Reset (rst_n low, synchronous) sets both dimensions to 1 and drops busy
//   and out_strobe; the element store keeps no reset value.
module matrix_rotation_engine_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  mre_pkg::in_item_t         in_item,
  output logic                      out_strobe,
  output mre_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mre_pkg::CNT_W-1:0] cfg_wdata
);

  mre_pkg::cmd_t cmd;
  mre_pkg::sts_t sts;

  mre_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mre_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: rtl/mre_checker.sv
// mre_checker: port-level assertions for matrix_rotation_engine_core
// depends on mre_pkg; bound to the top level below
module mre_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input mre_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input mre_pkg::out_item_t out_item
);

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.error_flag |-> out_item.row_last)
    else $error("error result without row_last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.error_flag |-> out_item.out_value == '0)
    else $error("error result with nonzero value");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("activity right after reset");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.operation == mre_pkg::OP_WRITE |=> !out_strobe)
    else $error("write item produced a result");

endmodule

bind matrix_rotation_engine_core mre_checker u_mre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

FILE: tb/sv/matrix_rotation_engine_core_test.sv
// matrix_rotation_engine_core_test: self-checking testbench for the matrix rotation engine
// drives element writes and rotate requests, predicts each rotated row and checks it
// depends on mre_pkg and matrix_rotation_engine_core
module matrix_rotation_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mre_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 500;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_strobe;
  out_item_t        out_item;
  logic             cfg_we;
  logic             cfg_index;
  logic [CNT_W-1:0] cfg_wdata;

  logic signed [DATA_W-1:0] shadow_store [0:DEPTH-1];
  bit                       stored       [0:DEPTH-1];
  logic [CNT_W-1:0]         row_setting;
  logic [CNT_W-1:0]         col_setting;
  out_item_t                pending_elems[$];
  int                       error_count;
  int                       sent_items;
  int                       quiet_cycles;
  int                       burst_left;

  matrix_rotation_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int fit_dim(logic [CNT_W-1:0] v);
    return (v == 0) ? 1 : ((v > MAX_DIM) ? MAX_DIM : int'(v));
  endfunction

  function automatic int out_rows(logic [1:0] ang);
    return (ang == ANG_180) ? fit_dim(row_setting) : fit_dim(col_setting);
  endfunction

  function automatic int row_length(logic [1:0] ang);
    return (ang == ANG_180) ? fit_dim(col_setting) : fit_dim(row_setting);
  endfunction

  // store address of element k of rotated output row r
  function automatic int walk_addr(logic [1:0] ang, int r, int k);
    int nr;
    int nc;
    nr = fit_dim(row_setting);
    nc = fit_dim(col_setting);
    case (ang)
      ANG_90:  return (nr - 1 - k) * MAX_DIM + r;
      ANG_180: return (nr - 1 - r) * MAX_DIM + (nc - 1 - k);
      default: return k * MAX_DIM + (nc - 1 - r);
    endcase
  endfunction

  function automatic void predict_rotation(in_item_t it);
    out_item_t e;
    int        len;
    if (it.angle_code == ANG_BAD || int'(it.row_index) >= out_rows(it.angle_code)) begin
      e.out_value  = '0;
      e.row_last   = 1'b1;
      e.error_flag = 1'b1;
      pending_elems.push_back(e);
    end else begin
      len = row_length(it.angle_code);
      for (int k = 0; k < len; k++) begin
        e.out_value  = shadow_store[walk_addr(it.angle_code, int'(it.row_index), k)];
        e.row_last   = (k == len - 1);
        e.error_flag = 1'b0;
        pending_elems.push_back(e);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          row_setting = cfg_wdata;
        end else begin
          col_setting = cfg_wdata;
        end
      end
      if (start && !busy) begin
        if (in_item.operation == OP_WRITE) begin
          shadow_store[{in_item.row_index, in_item.col_index}] = in_item.element_value;
        end else begin
          predict_rotation(in_item);
        end
      end
      if (out_strobe) begin
        if (pending_elems.size() == 0) begin
          $display("%0t: unexpected result value %0d last %0b err %0b", $time,
                   out_item.out_value, out_item.row_last, out_item.error_flag);
          error_count++;
        end else if (out_item !== pending_elems[0]) begin
          $display("%0t: expected value %0d last %0b err %0b, got value %0d last %0b err %0b",
                   $time, pending_elems[0].out_value, pending_elems[0].row_last,
                   pending_elems[0].error_flag, out_item.out_value, out_item.row_last,
                   out_item.error_flag);
          error_count++;
          void'(pending_elems.pop_front());
        end else begin
          void'(pending_elems.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.operation == OP_WRITE) begin
      stored[{it.row_index, it.col_index}] = 1'b1;
    end
    sent_items++;
  endtask

  task automatic write_elem(int r, int c, logic signed [DATA_W-1:0] v);
    in_item_t it;
    it.operation     = OP_WRITE;
    it.row_index     = DIM_W'(r);
    it.col_index     = DIM_W'(c);
    it.element_value = v;
    it.angle_code    = 2'($urandom_range(0, 3));
    send_item(it);
  endtask

  // writes any element of the walk that was never written, then asks for the row
  task automatic rotate_row(logic [1:0] ang, int r);
    in_item_t it;
    int       a;
    if (ang != ANG_BAD && r < out_rows(ang)) begin
      for (int k = 0; k < row_length(ang); k++) begin
        a = walk_addr(ang, r, k);
        if (!stored[a]) write_elem(a / MAX_DIM, a % MAX_DIM, $urandom);
      end
    end
    it.operation     = OP_ROTATE;
    it.row_index     = DIM_W'(r);
    it.col_index     = DIM_W'($urandom_range(0, MAX_DIM - 1));
    it.element_value = $urandom;
    it.angle_code    = ang;
    send_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(int rows, int cols);
    cfg_write(CFG_ROW_COUNT, CNT_W'(rows));
    cfg_write(CFG_COL_COUNT, CNT_W'(cols));
  endtask

  task automatic test_reset_dims();
    write_elem(0, 0, 32'sh7fffffff);
    rotate_row(ANG_90, 0);
    rotate_row(ANG_180, 0);
    rotate_row(ANG_270, 0);
    rotate_row(ANG_90, 1);
    rotate_row(ANG_BAD, 0);
    drain();
  endtask

  task automatic test_value_extremes();
    set_dims(2, 2);
    write_elem(0, 0, 32'sh80000000);
    write_elem(0, 1, 32'sh7fffffff);
    write_elem(1, 0, 32'sh00000000);
    write_elem(1, 1, -32'sd1);
    for (int a = 0; a < 3; a++) begin
      rotate_row(2'(a), 0);
      rotate_row(2'(a), 1);
    end
    drain();
  endtask

  task automatic test_bad_requests();
    set_dims(3, 5);
    write_elem(40, 50, 32'sh12345678);
    write_elem(63, 63, 32'sh5a5aa5a5);
    rotate_row(ANG_BAD, 0);
    rotate_row(ANG_BAD, 63);
    rotate_row(ANG_90, 5);
    rotate_row(ANG_90, 4);
    rotate_row(ANG_180, 3);
    rotate_row(ANG_180, 2);
    rotate_row(ANG_270, 5);
    rotate_row(ANG_270, 63);
    rotate_row(ANG_270, 4);
    drain();
  endtask

  task automatic test_dim_clamp();
    set_dims(0, 127);
    rotate_row(ANG_180, 0);
    rotate_row(ANG_180, 1);
    rotate_row(ANG_90, 63);
    rotate_row(ANG_270, 0);
    drain();
    set_dims(127, 0);
    rotate_row(ANG_90, 0);
    rotate_row(ANG_180, 63);
    rotate_row(ANG_270, 1);
    drain();
  endtask

  task automatic test_full_size();
    set_dims(64, 64);
    rotate_row(ANG_90, 0);
    rotate_row(ANG_90, 63);
    rotate_row(ANG_180, 0);
    rotate_row(ANG_180, 63);
    rotate_row(ANG_270, 0);
    rotate_row(ANG_270, 63);
    drain();
  endtask

  task automatic test_random_traffic();
    int       first;
    int       phase_len;
    int       p;
    int       nr;
    int       nc;
    int       rows_out;
    logic [1:0] ang;
    first = sent_items;
    while (sent_items - first < RANDOM_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        set_dims($urandom_range(1, 8), $urandom_range(1, 8));
      end else if (p < 90) begin
        set_dims($urandom_range(1, 64), $urandom_range(1, 64));
      end else begin
        set_dims($urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                 $urandom_range(0, 1) ? 0 : $urandom_range(65, 127));
      end
      nr = fit_dim(row_setting);
      nc = fit_dim(col_setting);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        p = $urandom_range(0, 99);
        if (p < 35) begin
          if ($urandom_range(0, 4) == 0) begin
            write_elem($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
          end else begin
            write_elem($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), $urandom);
          end
        end else if (p < 88) begin
          ang = 2'($urandom_range(0, 2));
          rotate_row(ang, $urandom_range(0, out_rows(ang) - 1));
        end else begin
          ang = 2'($urandom_range(0, 3));
          rows_out = out_rows(ang);
          if (ang == ANG_BAD || rows_out >= MAX_DIM) begin
            rotate_row(ANG_BAD, $urandom_range(0, 63));
          end else begin
            rotate_row(ang, $urandom_range(rows_out, 63));
          end
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_item     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_ROW_COUNT;
    cfg_wdata   <= '0;
    row_setting  = CNT_W'(1);
    col_setting  = CNT_W'(1);
    error_count  = 0;
    sent_items   = 0;
    burst_left   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_dims();
    test_value_extremes();
    test_bad_requests();
    test_dim_clamp();
    test_full_size();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_elems.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mre_pkg.sv
rtl/mre_ctrl.sv
rtl/mre_datapath.sv
rtl/matrix_rotation_engine_core.sv
rtl/mre_checker.sv
tb/sv/matrix_rotation_engine_core_test.sv
